>>> hw/rtl/rbv_pkg.sv
// ----------------------------------------------------------------------------
// rbv_pkg
// Types, latencies and arithmetic helpers for the rotation-between-vectors unit.
// ----------------------------------------------------------------------------
package rbv_pkg;

  localparam int IN_WIDTH      = 16;
  localparam int OUT_FRAC_BITS = 14;
  localparam int OUT_WIDTH     = OUT_FRAC_BITS + 2;
  localparam int OUT_SH        = 30 - OUT_FRAC_BITS;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;
  localparam int UNIT_LAT   = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;
  localparam int FIN_LAT    = 5;
  localparam int TOTAL_LAT  = 2 * UNIT_LAT + 2 + FIN_LAT;

  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

  typedef logic signed [31:0] q30_t;
  typedef logic [14:0]        wval_t;

  typedef struct packed {
    logic signed [IN_WIDTH-1:0] before_x;
    logic signed [IN_WIDTH-1:0] before_y;
    logic signed [IN_WIDTH-1:0] before_z;
    logic signed [IN_WIDTH-1:0] after_x;
    logic signed [IN_WIDTH-1:0] after_y;
    logic signed [IN_WIDTH-1:0] after_z;
  } vec_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] m00;
    logic signed [OUT_WIDTH-1:0] m01;
    logic signed [OUT_WIDTH-1:0] m02;
    logic signed [OUT_WIDTH-1:0] m10;
    logic signed [OUT_WIDTH-1:0] m11;
    logic signed [OUT_WIDTH-1:0] m12;
    logic signed [OUT_WIDTH-1:0] m20;
    logic signed [OUT_WIDTH-1:0] m21;
    logic signed [OUT_WIDTH-1:0] m22;
    logic                        axis_degenerate;
  } rot_t;

  typedef struct packed {
    wval_t [2:0] w;
    logic  [2:0] sgn;
    logic        nz;
  } norm_t;

  typedef struct packed {
    logic [2:0] sgn;
    logic       nz;
  } usgn_t;

  typedef struct packed {
    logic [34:0] rem;
    logic [31:0] root;
    logic [63:0] n;
  } sqrt_t;

  typedef struct packed {
    logic [30:0] r;
    logic [30:0] q;
    logic [30:0] n;
    logic [30:0] d;
  } div_t;

  function automatic sqrt_t sqrt_step(input sqrt_t s);
    logic [34:0] t;
    logic [34:0] trial;
    sqrt_t       o;
    t     = {s.rem[32:0], s.n[63:62]};
    trial = {1'b0, s.root, 2'b01};
    o     = s;
    o.n   = {s.n[61:0], 2'b00};
    if (t >= trial) begin
      o.rem  = t - trial;
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = t;
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  function automatic div_t div_step(input div_t s);
    logic [31:0] t;
    div_t        o;
    t   = {s.r, s.n[30]};
    o   = s;
    o.n = {s.n[29:0], 1'b0};
    if (t >= {1'b0, s.d}) begin
      o.r = 31'(t - {1'b0, s.d});
      o.q = {s.q[29:0], 1'b1};
    end else begin
      o.r = t[30:0];
      o.q = {s.q[29:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic [4:0] lod32(input logic [31:0] m);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (m[i]) p = 5'(i);
    end
    return p;
  endfunction

  function automatic logic signed [35:0] rnd30(input logic signed [65:0] v);
    logic [65:0] mag;
    logic [65:0] r;
    mag = v[65] ? 66'(-v) : 66'(v);
    r   = (mag + (66'd1 << 29)) >> 30;
    return v[65] ? $signed(36'd0 - r[35:0]) : $signed(r[35:0]);
  endfunction

  function automatic logic signed [OUT_WIDTH-1:0] to_out(input logic signed [33:0] r);
    logic [33:0] mag;
    logic [33:0] rr;
    logic [34:0] v;
    mag = r[33] ? 34'(-r) : 34'(r);
    rr  = (mag + ((34'd1 << OUT_SH) >> 1)) >> OUT_SH;
    if (rr > (34'd1 << OUT_FRAC_BITS)) rr = 34'd1 << OUT_FRAC_BITS;
    v = r[33] ? (35'd0 - {1'b0, rr}) : {1'b0, rr};
    return $signed(v[OUT_WIDTH-1:0]);
  endfunction

endpackage

>>> hw/rtl/rbv_sqrt.sv
// ----------------------------------------------------------------------------
// rbv_sqrt
// Pipelined integer square root, one result bit per stage, floor rounding.
// ----------------------------------------------------------------------------
module rbv_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] n,
  output logic [31:0] root
);

  rbv_pkg::sqrt_t st [rbv_pkg::SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= rbv_pkg::sqrt_step('{rem: '0, root: '0, n: n});
      for (int j = 1; j < rbv_pkg::SQRT_STEPS; j++) begin
        st[j] <= rbv_pkg::sqrt_step(st[j-1]);
      end
    end
  end

  assign root = st[rbv_pkg::SQRT_STEPS-1].root;

endmodule

>>> hw/rtl/rbv_unit.sv
// ----------------------------------------------------------------------------
// rbv_unit
// Pipelined vector normalizer: 3-D signed vector in, Q30 unit vector out.
// ----------------------------------------------------------------------------
module rbv_unit (
  input  logic          clk,
  input  logic          en,
  input  rbv_pkg::q30_t v [3],
  output rbv_pkg::q30_t u [3],
  output logic          nz
);

  localparam int ND_LEN = rbv_pkg::SQRT_STEPS + 2;

  logic [31:0]           mag1 [3];
  logic [2:0]            sg1;
  logic [31:0]           mag2 [3];
  logic [2:0]            sg2;
  logic [4:0]            p2;
  logic                  nz2;
  logic [31:0]           mx;
  rbv_pkg::norm_t        nrm;
  logic [29:0]           sq [3];
  logic [31:0]           n2;
  logic [31:0]           len;
  rbv_pkg::norm_t        nd [ND_LEN];
  rbv_pkg::div_t         ds [3][rbv_pkg::DIV_STEPS+1];
  rbv_pkg::usgn_t        dsb [rbv_pkg::DIV_STEPS+1];
  logic [59:0]           num [3];

  always_comb begin
    mx = mag1[0];
    if (mag1[1] > mx) mx = mag1[1];
    if (mag1[2] > mx) mx = mag1[2];
    for (int c = 0; c < 3; c++) begin
      num[c] = (60'(nd[ND_LEN-1].w[c]) << 44) + 60'(len >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        mag1[c] <= v[c][31] ? 32'(-v[c]) : 32'(v[c]);
        sg1[c]  <= v[c][31];
        mag2[c] <= mag1[c];
        nrm.w[c] <= (p2 > 5'd14) ? 15'(mag2[c] >> (p2 - 5'd14))
                                 : 15'(mag2[c] << (5'd14 - p2));
        sq[c]   <= 30'(nrm.w[c]) * 30'(nrm.w[c]);
      end
      sg2     <= sg1;
      p2      <= rbv_pkg::lod32(mx);
      nz2     <= (mx != 32'd0);
      nrm.sgn <= sg2;
      nrm.nz  <= nz2;
      n2      <= 32'(sq[0]) + 32'(sq[1]) + 32'(sq[2]);

      nd[0] <= nrm;
      for (int j = 1; j < ND_LEN; j++) begin
        nd[j] <= nd[j-1];
      end

      for (int c = 0; c < 3; c++) begin
        ds[c][0] <= '{r: 31'(num[c][59:31]), q: '0, n: num[c][30:0],
                      d: nd[ND_LEN-1].nz ? len[30:0] : 31'd1};
        for (int j = 1; j <= rbv_pkg::DIV_STEPS; j++) begin
          ds[c][j] <= rbv_pkg::div_step(ds[c][j-1]);
        end
      end
      dsb[0] <= '{sgn: nd[ND_LEN-1].sgn, nz: nd[ND_LEN-1].nz};
      for (int j = 1; j <= rbv_pkg::DIV_STEPS; j++) begin
        dsb[j] <= dsb[j-1];
      end

      for (int c = 0; c < 3; c++) begin
        if (!dsb[rbv_pkg::DIV_STEPS].nz) begin
          u[c] <= '0;
        end else if (dsb[rbv_pkg::DIV_STEPS].sgn[c]) begin
          u[c] <= -$signed({1'b0, ds[c][rbv_pkg::DIV_STEPS].q});
        end else begin
          u[c] <= $signed({1'b0, ds[c][rbv_pkg::DIV_STEPS].q});
        end
      end
      nz <= dsb[rbv_pkg::DIV_STEPS].nz;
    end
  end

  rbv_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .n    ({4'b0, n2, 28'b0}),
    .root (len)
  );

endmodule

>>> hw/rtl/rotation_between_two_vectors_unit.sv
// ----------------------------------------------------------------------------
// rotation_between_two_vectors_unit
// Rodrigues rotation matrix (Q1.14) that turns one 3-D vector onto another.
// ----------------------------------------------------------------------------
// Takes one vector pair per cycle and presents the 3x3 matrices on rot in the
// order the pairs were accepted; back-pressure on rot stalls the whole pipeline
// in place. Its 147 stages are two 70-stage normalizers in series (source and
// destination in parallel, then axis; each has a 32-stage square root and a
// 31-stage divider), two-stage dot/cross product and five-stage matrix assembly.
module rotation_between_two_vectors_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          vec_valid,
  output logic          vec_ready,
  input  rbv_pkg::vec_t vec,
  output logic          rot_valid,
  input  logic          rot_ready,
  output rbv_pkg::rot_t rot
);

  localparam int CD_LEN  = rbv_pkg::SQRT_STEPS + 3;
  localparam int CSD_LEN = rbv_pkg::UNIT_LAT - rbv_pkg::SQRT_STEPS - 2;

  typedef struct packed {
    logic signed [31:0] c;
    logic [30:0]        s;
  } cs_t;

  logic                     adv;
  logic [rbv_pkg::TOTAL_LAT-1:0] vld;

  rbv_pkg::q30_t      va [3];
  rbv_pkg::q30_t      vb [3];
  rbv_pkg::q30_t      ua [3];
  rbv_pkg::q30_t      ub [3];
  logic signed [63:0] pr [9];
  logic signed [65:0] dot;
  logic signed [35:0] cr;
  logic signed [31:0] c;
  rbv_pkg::q30_t      k [3];
  logic signed [63:0] ksq [3];
  logic [63:0]        k2;
  logic [31:0]        sraw;
  logic signed [31:0] cd [CD_LEN];
  cs_t                csd [CSD_LEN];
  rbv_pkg::q30_t      ax [3];
  logic               nzk;

  logic signed [63:0] f1p [9];
  logic signed [31:0] f1c;
  logic               f1dg;
  logic signed [31:0] f2x [9];
  logic signed [31:0] f2c;
  logic signed [32:0] f2omc;
  logic               f2dg;
  logic signed [64:0] f3p [6];
  logic signed [31:0] f3as [3];
  logic signed [31:0] f3c;
  logic               f3dg;
  logic signed [33:0] t [6];
  logic signed [33:0] r [9];
  logic               f4dg;

  assign adv       = !rot_valid || rot_ready;
  assign vec_ready = adv;
  assign rot_valid = vld[rbv_pkg::TOTAL_LAT-1];

  assign va[0] = 32'(vec.before_x);
  assign va[1] = 32'(vec.before_y);
  assign va[2] = 32'(vec.before_z);
  assign vb[0] = 32'(vec.after_x);
  assign vb[1] = 32'(vec.after_y);
  assign vb[2] = 32'(vec.after_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[rbv_pkg::TOTAL_LAT-2:0], vec_valid};
    end
  end

  rbv_unit u_src (.clk(clk), .en(adv), .v(va), .u(ua), .nz());
  rbv_unit u_dst (.clk(clk), .en(adv), .v(vb), .u(ub), .nz());

  always_comb begin
    dot = 66'(pr[0]) + 66'(pr[1]) + 66'(pr[2]);
    cr  = rbv_pkg::rnd30(dot);
    if (cr > 36'(rbv_pkg::ONE_Q30)) begin
      c = rbv_pkg::ONE_Q30;
    end else if (cr < -36'(rbv_pkg::ONE_Q30)) begin
      c = -rbv_pkg::ONE_Q30;
    end else begin
      c = 32'(cr);
    end
    for (int i = 0; i < 6; i++) begin
      t[i] = 34'(rbv_pkg::rnd30(66'(f3p[i])));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pr[0] <= ua[0] * ub[0];
      pr[1] <= ua[1] * ub[1];
      pr[2] <= ua[2] * ub[2];
      pr[3] <= ua[1] * ub[2];
      pr[4] <= ua[2] * ub[1];
      pr[5] <= ua[2] * ub[0];
      pr[6] <= ua[0] * ub[2];
      pr[7] <= ua[0] * ub[1];
      pr[8] <= ua[1] * ub[0];

      k[0] <= 32'(rbv_pkg::rnd30(66'(pr[3]) - 66'(pr[4])));
      k[1] <= 32'(rbv_pkg::rnd30(66'(pr[5]) - 66'(pr[6])));
      k[2] <= 32'(rbv_pkg::rnd30(66'(pr[7]) - 66'(pr[8])));

      for (int i = 0; i < 3; i++) begin
        ksq[i] <= k[i] * k[i];
      end
      k2 <= 64'(ksq[0] + ksq[1] + ksq[2]);

      cd[0] <= c;
      for (int j = 1; j < CD_LEN; j++) begin
        cd[j] <= cd[j-1];
      end
      csd[0] <= '{c: cd[CD_LEN-1],
                  s: (sraw > 32'(rbv_pkg::ONE_Q30)) ? 31'(rbv_pkg::ONE_Q30) : sraw[30:0]};
      for (int j = 1; j < CSD_LEN; j++) begin
        csd[j] <= csd[j-1];
      end

      f1p[0] <= ax[0] * ax[0];
      f1p[1] <= ax[1] * ax[1];
      f1p[2] <= ax[2] * ax[2];
      f1p[3] <= ax[0] * ax[1];
      f1p[4] <= ax[0] * ax[2];
      f1p[5] <= ax[1] * ax[2];
      f1p[6] <= ax[0] * $signed({1'b0, csd[CSD_LEN-1].s});
      f1p[7] <= ax[1] * $signed({1'b0, csd[CSD_LEN-1].s});
      f1p[8] <= ax[2] * $signed({1'b0, csd[CSD_LEN-1].s});
      f1c    <= csd[CSD_LEN-1].c;
      f1dg   <= !nzk;

      for (int i = 0; i < 9; i++) begin
        f2x[i] <= 32'(rbv_pkg::rnd30(66'(f1p[i])));
      end
      f2c   <= f1c;
      f2omc <= 33'(rbv_pkg::ONE_Q30) - 33'(f1c);
      f2dg  <= f1dg;

      for (int i = 0; i < 6; i++) begin
        f3p[i] <= f2x[i] * f2omc;
      end
      for (int i = 0; i < 3; i++) begin
        f3as[i] <= f2x[6+i];
      end
      f3c  <= f2c;
      f3dg <= f2dg;

      r[0] <= 34'(f3c) + t[0];
      r[1] <= t[3] - 34'(f3as[2]);
      r[2] <= 34'(f3as[1]) + t[4];
      r[3] <= 34'(f3as[2]) + t[3];
      r[4] <= 34'(f3c) + t[1];
      r[5] <= t[5] - 34'(f3as[0]);
      r[6] <= t[4] - 34'(f3as[1]);
      r[7] <= 34'(f3as[0]) + t[5];
      r[8] <= 34'(f3c) + t[2];
      f4dg <= f3dg;

      rot.m00 <= rbv_pkg::to_out(r[0]);
      rot.m01 <= rbv_pkg::to_out(r[1]);
      rot.m02 <= rbv_pkg::to_out(r[2]);
      rot.m10 <= rbv_pkg::to_out(r[3]);
      rot.m11 <= rbv_pkg::to_out(r[4]);
      rot.m12 <= rbv_pkg::to_out(r[5]);
      rot.m20 <= rbv_pkg::to_out(r[6]);
      rot.m21 <= rbv_pkg::to_out(r[7]);
      rot.m22 <= rbv_pkg::to_out(r[8]);
      rot.axis_degenerate <= f4dg;
    end
  end

  rbv_unit u_axis (.clk(clk), .en(adv), .v(k), .u(ax), .nz(nzk));

  rbv_sqrt u_sine (
    .clk  (clk),
    .en   (adv),
    .n    (k2),
    .root (sraw)
  );

endmodule

>>> verif/rotation_between_two_vectors_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotation_between_two_vectors_unit_tb
// Self-checking bench for the Rodrigues rotation unit: directed table of vector
// pairs, then random pairs, checked against table entries or an integer model of
// the datapath, under random valid/ready idling and a long output hold-off.
// ----------------------------------------------------------------------------
module rotation_between_two_vectors_unit_tb;

  localparam int    N_RANDOM  = 1800;
  localparam int    MAX_CYC   = 400000;
  localparam int    N_DIRECT  = 18;
  localparam int    LIM_OUT   = 1 << rbv_pkg::OUT_FRAC_BITS;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           vec_valid = 1'b0;
  logic           vec_ready;
  rbv_pkg::vec_t  vec = '0;
  logic           rot_valid;
  logic           rot_ready = 1'b0;
  rbv_pkg::rot_t  rot;

  rbv_pkg::rot_t  rot_q[$];
  int    errors = 0;
  int    cycles = 0;
  int    send_idle = 0;
  int    recv_stall = 0;
  bit    hold_req = 1'b0;
  bit    hold_seen = 1'b0;
  int    hold_left = 0;

  always #2 clk = ~clk;

  rotation_between_two_vectors_unit u_top (
    .clk(clk), .rst(rst), .vec_valid(vec_valid), .vec_ready(vec_ready), .vec(vec),
    .rot_valid(rot_valid), .rot_ready(rot_ready), .rot(rot)
  );

  function automatic longint shr_rnd(input longint v, input int sh);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint isqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic bit unitize(input longint v[3], output longint u[3]);
    longint unsigned mx, w[3], n2, len, q, a;
    int p;
    mx = 0;
    n2 = 0;
    p  = 0;
    for (int i = 0; i < 3; i++) begin
      a = v[i] < 0 ? -v[i] : v[i];
      if (a > mx) mx = a;
    end
    if (mx == 0) begin
      u = '{0, 0, 0};
      return 1'b0;
    end
    while (p < 63 && (mx >> (p + 1)) != 0) p++;
    for (int i = 0; i < 3; i++) begin
      a = v[i] < 0 ? -v[i] : v[i];
      a &= 64'hFF_FFFF_FFFF;
      w[i] = p > 14 ? (a >> (p - 14)) : (a << (14 - p));
      n2 += w[i] * w[i];
    end
    len = isqrt(n2 << 28);
    for (int i = 0; i < 3; i++) begin
      q = ((w[i] << 44) + (len >> 1)) / len;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic longint qm(input longint a, input longint b);
    return shr_rnd(a * b, 30);
  endfunction

  function automatic logic signed [rbv_pkg::OUT_WIDTH-1:0] quant(input longint q30);
    longint v;
    v = shr_rnd(q30, 30 - rbv_pkg::OUT_FRAC_BITS);
    if (v > LIM_OUT) v = LIM_OUT;
    if (v < -LIM_OUT) v = -LIM_OUT;
    return rbv_pkg::OUT_WIDTH'(v);
  endfunction

  function automatic rbv_pkg::rot_t rodrigues(input rbv_pkg::vec_t x);
    longint a[3], b[3], ua[3], ub[3], k[3], ax[3], r[9];
    longint c, s, omc, one;
    longint unsigned k2;
    bit ok;
    rbv_pkg::rot_t o;
    one = 64'sd1 <<< 30;
    a = '{longint'(x.before_x), longint'(x.before_y), longint'(x.before_z)};
    b = '{longint'(x.after_x), longint'(x.after_y), longint'(x.after_z)};
    ok = unitize(a, ua);
    ok = unitize(b, ub);
    c = shr_rnd(ua[0] * ub[0] + ua[1] * ub[1] + ua[2] * ub[2], 30);
    if (c > one) c = one;
    if (c < -one) c = -one;
    k[0] = shr_rnd(ua[1] * ub[2] - ua[2] * ub[1], 30);
    k[1] = shr_rnd(ua[2] * ub[0] - ua[0] * ub[2], 30);
    k[2] = shr_rnd(ua[0] * ub[1] - ua[1] * ub[0], 30);
    k2 = 0;
    for (int i = 0; i < 3; i++) k2 += longint'(k[i] * k[i]);
    s = isqrt(k2);
    if (s > one) s = one;
    ok = unitize(k, ax);
    omc = one - c;
    r[0] = c + qm(qm(ax[0], ax[0]), omc);
    r[1] = qm(qm(ax[0], ax[1]), omc) - qm(ax[2], s);
    r[2] = qm(ax[1], s) + qm(qm(ax[0], ax[2]), omc);
    r[3] = qm(ax[2], s) + qm(qm(ax[0], ax[1]), omc);
    r[4] = c + qm(qm(ax[1], ax[1]), omc);
    r[5] = -qm(ax[0], s) + qm(qm(ax[1], ax[2]), omc);
    r[6] = -qm(ax[1], s) + qm(qm(ax[0], ax[2]), omc);
    r[7] = qm(ax[0], s) + qm(qm(ax[1], ax[2]), omc);
    r[8] = c + qm(qm(ax[2], ax[2]), omc);
    o.m00 = quant(r[0]);
    o.m01 = quant(r[1]);
    o.m02 = quant(r[2]);
    o.m10 = quant(r[3]);
    o.m11 = quant(r[4]);
    o.m12 = quant(r[5]);
    o.m20 = quant(r[6]);
    o.m21 = quant(r[7]);
    o.m22 = quant(r[8]);
    o.axis_degenerate = ~ok;
    return o;
  endfunction

  typedef struct {
    rbv_pkg::vec_t v;
    bit            typed;
    rbv_pkg::rot_t want;
  } row_t;

  function automatic rbv_pkg::rot_t diag(input int d, input bit dg);
    rbv_pkg::rot_t o;
    o = '0;
    o.m00 = rbv_pkg::OUT_WIDTH'(d);
    o.m11 = rbv_pkg::OUT_WIDTH'(d);
    o.m22 = rbv_pkg::OUT_WIDTH'(d);
    o.axis_degenerate = dg;
    return o;
  endfunction

  row_t directed[N_DIRECT];

  initial begin
    directed[0]  = '{'{0, 0, 0, 0, 0, 0}, 1, diag(0, 1)};
    directed[1]  = '{'{0, 0, 0, 5, -7, 3}, 1, diag(0, 1)};
    directed[2]  = '{'{1, 2, 3, 0, 0, 0}, 1, diag(0, 1)};
    directed[3]  = '{'{100, 0, 0, 7, 0, 0}, 1, diag(LIM_OUT, 1)};
    directed[4]  = '{'{0, -3, 0, 0, 9, 0}, 1, diag(-LIM_OUT, 1)};
    directed[5]  = '{'{32767, 32767, 32767, 1, 1, 1}, 1, diag(LIM_OUT, 1)};
    directed[6]  = '{'{-32768, -32768, -32768, 32767, 32767, 32767}, 0, '0};
    directed[7]  = '{'{-32768, 0, 0, 32767, 0, 0}, 1, diag(-LIM_OUT, 1)};
    directed[8]  = '{'{1, 0, 0, 0, 1, 0}, 0, '0};
    directed[9]  = '{'{0, 1, 0, 0, 0, 1}, 0, '0};
    directed[10] = '{'{0, 0, 1, 1, 0, 0}, 0, '0};
    directed[11] = '{'{32767, 0, 0, 32767, 1, 0}, 0, '0};
    directed[12] = '{'{-32768, 32767, -1, 1, -32768, 32767}, 0, '0};
    directed[13] = '{'{-1, -1, -1, 1, 1, 1}, 1, diag(-LIM_OUT, 1)};
    directed[14] = '{'{1, 0, 0, -1, 1, 0}, 0, '0};
    directed[15] = '{'{-21846, 21845, 0, 0, 0, -32768}, 0, '0};
    directed[16] = '{'{32767, 32766, 32765, 32766, 32767, 32765}, 0, '0};
    directed[17] = '{'{1, -1, 1, -32768, 32767, -32768}, 0, '0};
  end

  function automatic rbv_pkg::vec_t rand_pair();
    rbv_pkg::vec_t v;
    int sh;
    v = rbv_pkg::vec_t'({$urandom, $urandom, $urandom});
    case ($urandom_range(0, 7))
      0: v.after_x = v.before_x;
      1: begin
        sh = $urandom_range(0, 14);
        v.before_x = v.before_x >>> sh;
        v.before_y = v.before_y >>> sh;
        v.before_z = v.before_z >>> sh;
      end
      2: begin
        v.after_x = -(v.before_x >>> 1);
        v.after_y = -(v.before_y >>> 1);
        v.after_z = -(v.before_z >>> 1);
      end
      3: begin
        v.after_x = v.before_x + rbv_pkg::IN_WIDTH'($signed($urandom_range(0, 2)) - 1);
        v.after_y = v.before_y;
        v.after_z = v.before_z;
      end
      4: begin
        v.before_z = '0;
        v.after_y  = '0;
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic offer(input rbv_pkg::vec_t v, input bit typed, input rbv_pkg::rot_t want);
    while (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
      vec_valid <= 1'b0;
      @(posedge clk);
    end
    vec_valid <= 1'b1;
    vec <= v;
    rot_q.insert(rot_q.size(), typed ? want : rodrigues(v));
    @(posedge clk);
    while (!vec_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    vec_valid <= 1'b0;
    while (rot_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rot_ready <= 1'b0;
    end else if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= 600;
      rot_ready <= 1'b0;
    end else if (hold_left > 0) begin
      rot_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      rot_ready <= !(recv_stall > 0 && $urandom_range(0, 99) < recv_stall);
    end
  end

  always @(posedge clk) begin
    rbv_pkg::rot_t w;
    if (!rst && rot_valid && rot_ready) begin
      if (rot_q.size() == 0) begin
        $error("unexpected matrix word %h", rot);
        errors++;
      end else begin
        w = rot_q.pop_front();
        if (rot.m00 !== w.m00) begin $error("m00 exp %0d got %0d", w.m00, rot.m00); errors++; end
        if (rot.m01 !== w.m01) begin $error("m01 exp %0d got %0d", w.m01, rot.m01); errors++; end
        if (rot.m02 !== w.m02) begin $error("m02 exp %0d got %0d", w.m02, rot.m02); errors++; end
        if (rot.m10 !== w.m10) begin $error("m10 exp %0d got %0d", w.m10, rot.m10); errors++; end
        if (rot.m11 !== w.m11) begin $error("m11 exp %0d got %0d", w.m11, rot.m11); errors++; end
        if (rot.m12 !== w.m12) begin $error("m12 exp %0d got %0d", w.m12, rot.m12); errors++; end
        if (rot.m20 !== w.m20) begin $error("m20 exp %0d got %0d", w.m20, rot.m20); errors++; end
        if (rot.m21 !== w.m21) begin $error("m21 exp %0d got %0d", w.m21, rot.m21); errors++; end
        if (rot.m22 !== w.m22) begin $error("m22 exp %0d got %0d", w.m22, rot.m22); errors++; end
        if (rot.axis_degenerate !== w.axis_degenerate) begin
          $error("axis_degenerate exp %0b got %0b", w.axis_degenerate, rot.axis_degenerate);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < N_DIRECT; i++) offer(directed[i].v, directed[i].typed, directed[i].want);
    wait_drained();
    hold_req <= 1'b1;
    for (int i = 0; i < 300; i++) offer(rand_pair(), 0, '0);
    wait_drained();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 59; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 59; end
        3: begin send_idle = 20; recv_stall = 20; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      for (int i = 0; i < (N_RANDOM - 300) / 5; i++) offer(rand_pair(), 0, '0);
    end
    wait_drained();
    repeat (rbv_pkg::TOTAL_LAT + 20) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> rotation_between_two_vectors_unit.f
hw/rtl/rbv_pkg.sv
hw/rtl/rbv_sqrt.sv
hw/rtl/rbv_unit.sv
hw/rtl/rotation_between_two_vectors_unit.sv
verif/rotation_between_two_vectors_unit_tb.sv
